FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// property checked on every edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

FILE: hdl/slbm_pkg.sv
package slbm_pkg;

  // grid and chain geometry
  localparam int GRID_SIZE  = 16;
  localparam int GRID_W     = $clog2(GRID_SIZE);
  localparam int PIXELS     = 4;
  localparam int LED_COUNT  = GRID_SIZE * GRID_SIZE;
  localparam int LED_W      = 8;
  localparam int GROUPS     = (LED_COUNT + PIXELS - 1) / PIXELS;
  localparam int GRP_W      = $clog2(GROUPS);
  localparam int SLOT_W     = $clog2(PIXELS);

  // field widths
  localparam int LEVEL_W    = 8;
  localparam int SENS_W     = 4;
  localparam int COLOR_W    = 6;
  localparam int SENS_RESET = 1;

  // bar length arithmetic
  localparam int LEVEL_FULL = 130;
  localparam int PROD_W     = LEVEL_W + SENS_W + GRID_W;
  localparam int THR_W      = $clog2(LEVEL_FULL * (GRID_SIZE + 1) + 1);

  // brightness scale
  localparam int BRIGHT_MAX = 50;
  localparam int BR_W       = $clog2(BRIGHT_MAX * GRID_SIZE + 1);

  typedef logic [GRID_SIZE-1:0] grid_row_t;

  // finished bar row handed to the renderer
  typedef struct packed {
    logic      done;
    grid_row_t row;
  } bar_res_t;

  // brightness rising with position along the row
  function automatic logic [COLOR_W-1:0] bright_hi(input logic [GRID_W-1:0] pos);
    logic [BR_W-1:0] t;
    t = BR_W'(BRIGHT_MAX) * BR_W'(pos);
    return COLOR_W'(t >> GRID_W);
  endfunction

  // brightness falling with position along the row
  function automatic logic [COLOR_W-1:0] bright_lo(input logic [GRID_W-1:0] pos);
    logic [BR_W-1:0] t;
    t = BR_W'(BRIGHT_MAX) * (BR_W'(GRID_SIZE) - BR_W'(pos));
    return COLOR_W'(t >> GRID_W);
  endfunction

endpackage

FILE: hdl/slbm_bar_unit.sv
`include "assert_macros.svh"

module slbm_bar_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [slbm_pkg::LEVEL_W-1:0]    level,
  input  logic [slbm_pkg::SENS_W-1:0]     sensitivity,
  output slbm_pkg::bar_res_t              res
);
  import slbm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_CMP} state_t;

  state_t              state_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [SENS_W-1:0]   sens_r;
  logic [PROD_W-1:0]   prod_r;
  logic [THR_W-1:0]    thr_r;
  logic [GRID_W-1:0]   cnt_r;
  grid_row_t           row_r;
  logic                done_r;

  // one multiply, then one compare per column against a rising threshold:
  // column j is lit when (j+1)*130 <= level*sensitivity*16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            level_r <= level;
            sens_r  <= sensitivity;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          done_r  <= 1'b0;
          prod_r  <= (PROD_W'(level_r) * PROD_W'(sens_r)) << GRID_W;
          thr_r   <= THR_W'(LEVEL_FULL);
          cnt_r   <= '0;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          row_r  <= {(prod_r >= PROD_W'(thr_r)), row_r[GRID_SIZE-1:1]};
          thr_r  <= thr_r + THR_W'(LEVEL_FULL);
          cnt_r  <= cnt_r + 1'b1;
          done_r <= (cnt_r == GRID_W'(GRID_SIZE - 1));
          if (cnt_r == GRID_W'(GRID_SIZE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.row  = row_r;

  `ASSERT_PROP(a_done_pulse, clk, rst_n, done_r |=> !done_r)
  `ASSERT_PROP(a_done_after_last, clk, rst_n,
    (state_r == ST_CMP && cnt_r == GRID_W'(GRID_SIZE - 1)) |=> done_r)

endmodule

FILE: hdl/slbm_render.sv
`include "assert_macros.svh"

module slbm_render (
  input  logic                            clk,
  input  logic                            rst_n,
  input  slbm_pkg::bar_res_t              bar,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slbm_pkg::LED_W-1:0]      out_first_led_index,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_a,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_a,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_b,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_b,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_c,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_c,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_d,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_d,
  output logic                            out_frame_end
);
  import slbm_pkg::*;

  grid_row_t             grid_r [GRID_SIZE];
  logic                  active_r;
  logic [GRP_W-1:0]      grp_r;
  logic                  out_valid_r;
  logic [LED_W-1:0]      first_r;
  logic                  frame_end_r;
  logic [COLOR_W-1:0]    red_r   [4];
  logic [COLOR_W-1:0]    green_r [4];

  logic [GRID_W-1:0]     row_idx;
  grid_row_t             row_bits;
  logic                  odd_row;
  logic [COLOR_W-1:0]    red_nxt   [4];
  logic [COLOR_W-1:0]    green_nxt [4];
  logic                  load;

  // current group's row and the pixels it covers
  assign row_idx  = GRID_W'((32'(grp_r) * PIXELS) >> GRID_W);
  assign row_bits = grid_r[row_idx];
  assign odd_row  = row_idx[0];
  assign load     = active_r && (!out_valid_r || !out_stall);

  // color of each slot in the group, mirrored column on odd rows
  always_comb begin
    logic [LED_W+1:0]  n;
    logic [GRID_W-1:0] pos;
    logic [GRID_W-1:0] col;
    for (int s = 0; s < 4; s++) begin
      n   = (LED_W+2)'(grp_r) * (LED_W+2)'(PIXELS) + (LED_W+2)'(s);
      pos = n[GRID_W-1:0];
      col = odd_row ? GRID_W'(GRID_SIZE - 1) - pos : pos;
      if (s < PIXELS && n < (LED_W+2)'(LED_COUNT) && row_bits[col]) begin
        red_nxt[s]   = odd_row ? bright_hi(pos) : bright_lo(pos);
        green_nxt[s] = odd_row ? bright_lo(pos) : bright_hi(pos);
      end else begin
        red_nxt[s]   = '0;
        green_nxt[s] = '0;
      end
    end
  end

  // history shift on a new bar row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_SIZE; r++) begin
        grid_r[r] <= '0;
      end
    end else if (bar.done) begin
      for (int r = GRID_SIZE - 1; r > 0; r--) begin
        grid_r[r] <= grid_r[r-1];
      end
      grid_r[0] <= bar.row;
    end
  end

  // group sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !active_r) begin
        out_valid_r <= 1'b0;
      end
      if (bar.done) begin
        active_r <= 1'b1;
        grp_r    <= '0;
      end else if (load) begin
        out_valid_r <= 1'b1;
        first_r     <= LED_W'(32'(grp_r) * PIXELS);
        frame_end_r <= (grp_r == GRP_W'(GROUPS - 1));
        for (int s = 0; s < 4; s++) begin
          red_r[s]   <= red_nxt[s];
          green_r[s] <= green_nxt[s];
        end
        grp_r <= grp_r + 1'b1;
        if (grp_r == GRP_W'(GROUPS - 1)) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_first_led_index = first_r;
  assign out_frame_end       = frame_end_r;
  assign out_red_a           = red_r[0];
  assign out_green_a         = green_r[0];
  assign out_red_b           = red_r[1];
  assign out_green_b         = green_r[1];
  assign out_red_c           = red_r[2];
  assign out_green_c         = green_r[2];
  assign out_red_d           = red_r[3];
  assign out_green_d         = green_r[3];

  `ASSERT_PROP(a_bar_when_idle, clk, rst_n, bar.done |-> (!active_r && !out_valid_r))
  `ASSERT_PROP(a_end_index, clk, rst_n,
    (out_valid_r && frame_end_r) |-> (first_r == LED_W'(32'(GROUPS - 1) * PIXELS)))
  `ASSERT_PROP(a_frame_starts_at_zero, clk, rst_n,
    $rose(out_valid_r) |-> (first_r == '0))

endmodule

FILE: hdl/scrolling_level_bar_matrix.sv
// Level meter for a 16 by 16 serpentine LED matrix. Each accepted level word
// scrolls the history grid down one row and adds a new bar on top, with
// length min(16, level*sensitivity*16/130); the block then sends the whole
// frame as 64 words of four pixels, the last marked by out_frame_end. Each
// level word is captured, multiplied once, compared in the shared compare
// unit one grid column at a time, scrolled into the grid and sent as the 64
// output words; the next level word is taken only once the last word of the
// frame has been taken, so a stalled output word holds it off as well.
// in_stall stays high until the last word of the frame is taken, and also
// while cfg_valid is high, so a configuration write goes ahead of a level.
// cfg_sensitivity (reset 1) is written when cfg_valid and cfg_ready are both
// high; cfg_ready is low while a level is being processed.
module scrolling_level_bar_matrix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slbm_pkg::SENS_W-1:0]     cfg_sensitivity,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slbm_pkg::LEVEL_W-1:0]    in_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slbm_pkg::LED_W-1:0]      out_first_led_index,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_a,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_a,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_b,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_b,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_c,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_c,
  output logic [slbm_pkg::COLOR_W-1:0]    out_red_d,
  output logic [slbm_pkg::COLOR_W-1:0]    out_green_d,
  output logic                            out_frame_end
);
  import slbm_pkg::*;

  logic                busy_r;
  logic [SENS_W-1:0]   sens_r;
  logic                in_take;
  bar_res_t            bar;

  // a pending configuration write holds off the level word
  assign in_stall  = busy_r || cfg_valid;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !busy_r;

  // sensitivity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SENS_W'(SENS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      sens_r <= cfg_sensitivity;
    end
  end

  // busy from accepted level word until the frame's last word leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_take) begin
      busy_r <= 1'b1;
    end else if (out_valid && !out_stall && out_frame_end) begin
      busy_r <= 1'b0;
    end
  end

  slbm_bar_unit u_bar (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_take),
    .level       (in_level),
    .sensitivity (sens_r),
    .res         (bar)
  );

  slbm_render u_render (
    .clk                 (clk),
    .rst_n               (rst_n),
    .bar                 (bar),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_first_led_index (out_first_led_index),
    .out_red_a           (out_red_a),
    .out_green_a         (out_green_a),
    .out_red_b           (out_red_b),
    .out_green_b         (out_green_b),
    .out_red_c           (out_red_c),
    .out_green_c         (out_green_c),
    .out_red_d           (out_red_d),
    .out_green_d         (out_green_d),
    .out_frame_end       (out_frame_end)
  );

endmodule
